@@ hdl/fc_pkg.sv @@
package fc_pkg;

   localparam int MAX_TAPS_DEF    = 512;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CMD_BITS   = 2;
   localparam int VALUE_BITS = 16;
   localparam int INDEX_BITS = 9;
   localparam int KLEN_BITS  = 10;
   localparam int OUT_BITS   = 40;

   localparam logic [KLEN_BITS-1:0] KLEN_RESET = 10'd512;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_WRITE  = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic issue;
      logic use_tap;
   } mac_ctrl_type;

endpackage

@@ hdl/fc_if.sv @@
interface fc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [fc_pkg::CMD_BITS-1:0]   cmd;
   logic signed [fc_pkg::VALUE_BITS-1:0] value;
   logic        [fc_pkg::INDEX_BITS-1:0] coef_index;

   modport source (output valid, input ready, output cmd, output value, output coef_index);
   modport sink (input valid, output ready, input cmd, input value, input coef_index);
endinterface

interface fc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [fc_pkg::OUT_BITS-1:0] result_value;

   modport source (output valid, input ready, output result_value);
   modport sink (input valid, output ready, input result_value);
endinterface

@@ hdl/fc_ram.sv @@
module fc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                           wdata,
   output logic [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

@@ hdl/fc_cell.sv @@
module fc_cell #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          shift,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   output logic signed [SAMPLE_BITS-1:0] sample_out
);
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] sample_in_d;

   always_comb begin
      sample_in_d = sample_ff;
      if (clear) begin
         sample_in_d = '0;
      end else if (shift) begin
         sample_in_d = sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in_d;
      end
   end

   assign sample_out = sample_ff;
endmodule

@@ hdl/fc_mac.sv @@
module fc_mac #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fc_pkg::mac_ctrl_type                ctrl,
   input  logic signed [SAMPLE_BITS-1:0]       tap_sample,
   input  logic signed [SAMPLE_BITS-1:0]       coef,
   output logic signed [fc_pkg::OUT_BITS-1:0]  acc
);
   import fc_pkg::*;

   localparam int PW = 2 * SAMPLE_BITS;

   logic                          s1_valid_ff;
   logic                          s1_use_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic signed [PW-1:0]          product;
   logic signed [PW-1:0]          prod_ff;
   logic signed [PW-1:0]          prod_in;
   logic signed [OUT_BITS-1:0]    acc_ff;
   logic signed [OUT_BITS-1:0]    acc_in;

   assign product = s1_sample_ff * coef;
   assign prod_in = (s1_valid_ff && s1_use_ff) ? product : '0;
   assign acc_in  = ctrl.clear ? '0 : acc_ff + OUT_BITS'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_use_ff   <= 1'b0;
         prod_ff     <= '0;
         acc_ff      <= '0;
      end else begin
         s1_valid_ff <= ctrl.issue;
         s1_use_ff   <= ctrl.use_tap;
         prod_ff     <= prod_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sample_ff <= tap_sample;
   end

   assign acc = acc_ff;
endmodule

@@ hdl/fir_convolution.sv @@
// A coefficient write or a history clear leaves the block ready for the next transfer at once.
// A sample transfer starts a run in which the sample ring makes one full turn past a single
// MAC; the block takes no new request until the run has loaded its result for output.
// A result waiting in the output register does not hold up later writes or clears.
// Synchronous reset clears the sample history and sets the kernel length to 512 taps.
// Coefficients are undefined after reset until they are written.
module fir_convolution #(
   parameter int MAX_TAPS    = fc_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_BITS = fc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   fc_req_if.sink                         req_chan,
   fc_rsp_if.source                       rsp_chan,
   input  logic                           csr_we,
   input  logic [fc_pkg::KLEN_BITS-1:0]   csr_wdata
);
   import fc_pkg::*;

   localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CW = (AW > KLEN_BITS) ? AW : KLEN_BITS;
   localparam logic [AW-1:0] LAST_TAP   = AW'(MAX_TAPS - 1);
   localparam logic [1:0]    DRAIN_LAST = 2'd2;

   state_type                     state_ff;
   state_type                     state_in;
   logic [AW-1:0]                 tap_cnt_ff;
   logic [AW-1:0]                 tap_cnt_in;
   logic [1:0]                    drain_ff;
   logic [1:0]                    drain_in;
   logic [KLEN_BITS-1:0]          klen_ff;
   logic [KLEN_BITS-1:0]          klen_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [OUT_BITS-1:0]    rsp_data_ff;
   logic signed [OUT_BITS-1:0]    rsp_data_in;

   logic                          req_valid;
   logic                          req_ready;
   logic                          req_fire;
   logic [CMD_BITS-1:0]           req_cmd;
   logic                          rsp_ready;
   logic                          out_free;
   logic                          load;
   logic                          rotate;
   logic                          shift;
   logic                          clear;
   logic                          index_ok;
   logic                          ram_we;
   logic [AW-1:0]                 tap_addr;
   logic [AW-1:0]                 ram_addr;
   logic signed [SAMPLE_BITS-1:0] sample_word;
   logic signed [SAMPLE_BITS-1:0] ram_rdata;
   logic signed [SAMPLE_BITS-1:0] cell_q [MAX_TAPS];
   logic signed [OUT_BITS-1:0]    acc_value;
   mac_ctrl_type                  mac_ctrl;

   assign req_valid   = req_chan.valid;
   assign req_cmd     = req_chan.cmd;
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign req_chan.ready = req_ready;
   assign rsp_ready   = rsp_chan.ready;

   assign sample_word = SAMPLE_BITS'($unsigned(req_chan.value));
   assign index_ok    = 32'(req_chan.coef_index) < 32'(MAX_TAPS);

   assign rotate   = (state_ff == ST_RUN);
   assign shift    = rotate || (req_fire && (req_cmd == CMD_SAMPLE));
   assign clear    = req_fire && (req_cmd == CMD_CLEAR);
   assign ram_we   = req_fire && (req_cmd == CMD_WRITE) && index_ok;
   assign tap_addr = LAST_TAP - tap_cnt_ff;
   assign ram_addr = rotate ? tap_addr : AW'(req_chan.coef_index);

   assign mac_ctrl.clear   = req_fire && (req_cmd == CMD_SAMPLE);
   assign mac_ctrl.issue   = rotate;
   assign mac_ctrl.use_tap = CW'(tap_addr) < CW'(klen_ff);

   // The newest sample sits in the first cell; while running, the ring turns so that the last
   // cell presents the samples from oldest tap to newest.
   for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] cell_d;
      if (i == 0) begin : g_head
         assign cell_d = rotate ? cell_q[MAX_TAPS-1] : sample_word;
      end else begin : g_body
         assign cell_d = cell_q[i-1];
      end
      fc_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .clear      (clear),
         .shift      (shift),
         .sample_in  (cell_d),
         .sample_out (cell_q[i])
      );
   end

   fc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (sample_word),
      .rdata (ram_rdata)
   );

   fc_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .tap_sample (cell_q[MAX_TAPS-1]),
      .coef       (ram_rdata),
      .acc        (acc_value)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_cmd == CMD_SAMPLE)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (tap_cnt_ff == LAST_TAP) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      tap_cnt_in = '0;
      drain_in   = '0;
      load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_RUN: begin
            tap_cnt_in = tap_cnt_ff + AW'(1);
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 2'd1;
         end
         ST_FINISH: begin
            load = out_free;
         end
         default: begin
         end
      endcase
   end

   assign klen_in      = csr_we ? csr_wdata : klen_ff;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = load ? acc_value : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_cnt_ff   <= '0;
         drain_ff     <= '0;
         klen_ff      <= KLEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_cnt_ff   <= tap_cnt_in;
         drain_ff     <= drain_in;
         klen_ff      <= klen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_data_ff;
endmodule

@@ hdl/fc_checker.sv @@
module fc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [fc_pkg::CMD_BITS-1:0]         req_cmd,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [fc_pkg::OUT_BITS-1:0]  rsp_data
);
   import fc_pkg::*;

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   // A waiting result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before its transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while waiting");

   // A sample transfer keeps the block busy while the filter runs.
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_cmd == CMD_SAMPLE) |=> !req_ready)
      else $error("block took a request during a filter run");

   // Coefficient writes, clears and unused codes leave the block ready.
   a_other_ready: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_cmd != CMD_SAMPLE) |=> req_ready)
      else $error("non-sample transfer stalled the block");

   // A new result only appears at the end of a filter run.
   a_rsp_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a filter run");
endmodule

bind fir_convolution fc_checker u_fc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_cmd   (req_cmd),
   .rsp_valid (rsp_valid_ff),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data_ff)
);
